>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define KTUMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition never seen outside reset
`define KTUMS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hdl/ktums_pkg.sv
package ktums_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned KEY_W  = 16;
  localparam int unsigned CNT_W  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD     = 3'd0,
    CMD_UPDATE   = 3'd1,
    CMD_MAX      = 3'd2,
    CMD_SORT_CNT = 3'd3,
    CMD_SORT_KEY = 3'd4,
    CMD_DISPLAY  = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] out_slot;
    logic [KEY_W-1:0]  out_key;
    logic [CNT_W-1:0]  out_count;
    logic [CNT_W-1:0]  old_count;
    logic              last;
  } out_item_t;

endpackage

>>> hdl/ktums_in_if.sv
interface ktums_in_if;
  import ktums_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SLOT_W-1:0] slot;
  logic [KEY_W-1:0]  item_key;
  logic [CNT_W-1:0]  item_count;

  modport source (output valid, output cmd, output slot, output item_key,
                  output item_count, input ready);
  modport sink   (input valid, input cmd, input slot, input item_key,
                  input item_count, output ready);
endinterface

>>> hdl/ktums_out_if.sv
interface ktums_out_if;
  import ktums_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic [SLOT_W-1:0] out_slot;
  logic [KEY_W-1:0]  out_key;
  logic [CNT_W-1:0]  out_count;
  logic [CNT_W-1:0]  old_count;
  logic              last;

  modport source (output valid, output status, output out_slot, output out_key,
                  output out_count, output old_count, output last, input ready);
  modport sink   (input valid, input status, input out_slot, input out_key,
                  input out_count, input old_count, input last, output ready);
endinterface

>>> hdl/keyed_table_update_max_sort_core.sv
// Keyed table of ENTRIES key/count pairs held in one single-port-write,
// registered-read memory, driven by load, update, max query, sort and display
// commands. One command is taken at a time; every table read is a
// read-then-compare step on the memory's single read port. Display waits
// out any output stall, and either sort does one compare-and-swap per read
// step. The output register lets the next command in while a result waits
// to be taken. Entries never loaded read as zero through per-entry valid
// flops, so no clearing pass follows reset.
`include "assert_macros.svh"

module keyed_table_update_max_sort_core #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ktums_in_if.sink    in_i,
  ktums_out_if.source out_o
);
  import ktums_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);
  localparam logic [AW-1:0] PEN_IDX  = AW'(ENTRIES - 2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD,
    ST_CMP,
    ST_WB,
    ST_ACK
  } state_e;

  state_e            st_q, st_d;
  cmd_e              cmd_q, cmd_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     jdx_q, jdx_d;
  logic              sort_j_q, sort_j_d;
  entry_t            hold_q, hold_d;
  entry_t            best_q, best_d;
  logic [AW-1:0]     best_idx_q, best_idx_d;
  logic              out_vld_q, out_vld_d;
  out_item_t         out_q, out_d;

  entry_t            mem [ENTRIES];
  logic [ENTRIES-1:0] vld_q;
  entry_t            rd_data_q;
  logic              rd_vld_q;

  logic              wr_en, rd_en, emit, out_free, by_key, swap;
  logic [AW-1:0]     wr_addr, rd_addr;
  entry_t            wr_data, ent;
  out_item_t         res, ack_res;
  logic [CNT_W-1:0]  hold_v, ent_v;

  assign ent      = rd_vld_q ? rd_data_q : '0;
  assign out_free = !out_vld_q || out_o.ready;
  assign by_key   = (cmd_q == CMD_SORT_KEY);
  assign hold_v   = by_key ? hold_q.key : hold_q.count;
  assign ent_v    = by_key ? ent.key : ent.count;
  assign swap     = hold_v > ent_v;

  always_comb begin
    ack_res      = '0;
    ack_res.last = 1'b1;
    case (cmd_q)
      CMD_UPDATE: begin
        ack_res.status  = 1'b1;
        ack_res.out_key = key_q;
      end
      CMD_MAX: begin
        ack_res.out_slot  = SLOT_W'(best_idx_q);
        ack_res.out_key   = best_q.key;
        ack_res.out_count = best_q.count;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d       = st_q;
    cmd_d      = cmd_q;
    slot_d     = slot_q;
    key_d      = key_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    jdx_d      = jdx_q;
    sort_j_d   = sort_j_q;
    hold_d     = hold_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    wr_en      = 1'b0;
    wr_addr    = idx_q;
    wr_data    = ent;
    rd_en      = 1'b0;
    rd_addr    = sort_j_q ? jdx_q : idx_q;
    emit       = 1'b0;
    res        = '0;
    res.last   = 1'b1;

    if (out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d    = cmd_e'(in_i.cmd);
          slot_d   = in_i.slot;
          key_d    = in_i.item_key;
          cnt_d    = in_i.item_count;
          idx_d    = '0;
          sort_j_d = 1'b0;
          case (cmd_e'(in_i.cmd))
            CMD_LOAD: st_d = ST_LOAD;
            CMD_UPDATE, CMD_MAX, CMD_SORT_CNT, CMD_SORT_KEY, CMD_DISPLAY: st_d = ST_RD;
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          wr_en         = (32'(slot_q) < ENTRIES);
          wr_addr       = AW'(slot_q);
          wr_data       = '{key: key_q, count: cnt_q};
          emit          = 1'b1;
          res.out_slot  = slot_q;
          res.out_key   = key_q;
          res.out_count = cnt_q;
          st_d          = ST_IDLE;
        end
      end
      ST_RD: begin
        rd_en = 1'b1;
        st_d  = ST_CMP;
      end
      ST_CMP: begin
        case (cmd_q)
          CMD_UPDATE: begin
            if (ent.key == key_q) begin
              if (out_free) begin
                wr_en         = 1'b1;
                wr_data       = '{key: ent.key, count: cnt_q};
                emit          = 1'b1;
                res.out_slot  = SLOT_W'(idx_q);
                res.out_key   = key_q;
                res.out_count = cnt_q;
                res.old_count = ent.count;
                st_d          = ST_IDLE;
              end
            end else if (idx_q == LAST_IDX) begin
              st_d = ST_ACK;
            end else begin
              idx_d = idx_q + 1'b1;
              st_d  = ST_RD;
            end
          end
          CMD_MAX: begin
            if (idx_q == '0 || ent.count > best_q.count) begin
              best_d     = ent;
              best_idx_d = idx_q;
            end
            if (idx_q == LAST_IDX) begin
              st_d = ST_ACK;
            end else begin
              idx_d = idx_q + 1'b1;
              st_d  = ST_RD;
            end
          end
          CMD_DISPLAY: begin
            if (out_free) begin
              emit          = 1'b1;
              res.out_slot  = SLOT_W'(idx_q);
              res.out_key   = ent.key;
              res.out_count = ent.count;
              res.last      = (idx_q == LAST_IDX);
              if (idx_q == LAST_IDX) begin
                st_d = ST_IDLE;
              end else begin
                idx_d = idx_q + 1'b1;
                st_d  = ST_RD;
              end
            end
          end
          CMD_SORT_CNT, CMD_SORT_KEY: begin
            if (!sort_j_q) begin
              hold_d   = ent;
              jdx_d    = idx_q + 1'b1;
              sort_j_d = 1'b1;
              st_d     = ST_RD;
            end else begin
              if (swap) begin
                wr_en   = 1'b1;
                wr_addr = jdx_q;
                wr_data = hold_q;
                hold_d  = ent;
              end
              if (jdx_q == LAST_IDX) begin
                st_d = ST_WB;
              end else begin
                jdx_d = jdx_q + 1'b1;
                st_d  = ST_RD;
              end
            end
          end
          default: st_d = ST_IDLE;
        endcase
      end
      ST_WB: begin
        wr_en    = 1'b1;
        wr_addr  = idx_q;
        wr_data  = hold_q;
        sort_j_d = 1'b0;
        if (idx_q == PEN_IDX) begin
          st_d = ST_ACK;
        end else begin
          idx_d = idx_q + 1'b1;
          st_d  = ST_RD;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          emit = 1'b1;
          res  = ack_res;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    if (emit) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      cmd_q      <= CMD_LOAD;
      slot_q     <= '0;
      key_q      <= '0;
      cnt_q      <= '0;
      idx_q      <= '0;
      jdx_q      <= '0;
      sort_j_q   <= 1'b0;
      hold_q     <= '0;
      best_q     <= '0;
      best_idx_q <= '0;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      st_q       <= st_d;
      cmd_q      <= cmd_d;
      slot_q     <= slot_d;
      key_q      <= key_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      jdx_q      <= jdx_d;
      sort_j_q   <= sort_j_d;
      hold_q     <= hold_d;
      best_q     <= best_d;
      best_idx_q <= best_idx_d;
      out_vld_q  <= out_vld_d;
      out_q      <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  assign in_i.ready      = (st_q == ST_IDLE);
  assign out_o.valid     = out_vld_q;
  assign out_o.status    = out_q.status;
  assign out_o.out_slot  = out_q.out_slot;
  assign out_o.out_key   = out_q.out_key;
  assign out_o.out_count = out_q.out_count;
  assign out_o.old_count = out_q.old_count;
  assign out_o.last      = out_q.last;

  `KTUMS_ASSERT_NEVER(a_no_wr_idle, (st_q == ST_IDLE) && wr_en, "table written while idle")
  `KTUMS_ASSERT(a_cmp_after_rd,
                (st_q == ST_CMP) |-> $past(st_q == ST_RD || st_q == ST_CMP),
                "compare without a read")
  `KTUMS_ASSERT(a_sort_order, ((st_q == ST_CMP) && sort_j_q) |-> (jdx_q > idx_q),
                "sort partner not above pivot")
  `KTUMS_ASSERT(a_emit_busy, $rose(out_vld_q) |-> ($past(st_q) != ST_IDLE),
                "result raised from idle")

endmodule
